// ===== rtl/core/bpa_pkg.sv =====
// ---------------------------------------------------------------------------
// bpa_pkg
// Shared constants, request codes and bitmap word helpers for the
// bitmap page allocator.
// ---------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned NUM_PAGES = 65536;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned MAP_WORDS = NUM_PAGES / WORD_BITS;
  localparam int unsigned MAX_RUN   = 1024;

  localparam logic [15:0] BASE_RESET  = 16'd8192;
  localparam logic [16:0] TOTAL_RESET = 17'd65536;
  localparam logic [16:0] FREE_MAX    = 17'd65536;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_FREE    = 2'd1,
    KIND_RESERVE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic {
    REG_BASE  = 1'b0,
    REG_TOTAL = 1'b1
  } reg_idx_t;

  // Bits of word w that fall inside the page run [s, e).
  function automatic logic [63:0] word_mask(input logic [10:0] w,
                                            input logic [15:0] s,
                                            input logic [16:0] e);
    logic [5:0]  lo;
    logic [63:0] m_lo;
    logic [63:0] m_hi;
    lo   = (w == {1'b0, s[15:6]}) ? s[5:0] : 6'd0;
    m_lo = {64{1'b1}} << lo;
    m_hi = (w == e[16:6]) ? ~({64{1'b1}} << e[5:0]) : {64{1'b1}};
    return m_lo & m_hi;
  endfunction

  // Position of the lowest set bit.
  function automatic logic [5:0] first_set(input logic [63:0] m);
    logic [5:0] pos;
    pos = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (m[i]) pos = 6'(i);
    end
    return pos;
  endfunction

endpackage

// ===== rtl/core/bpa_div.sv =====
// ---------------------------------------------------------------------------
// bpa_div
// Restoring divider, one quotient bit per cycle: run offset over alignment.
// ---------------------------------------------------------------------------
module bpa_div
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [9:0]  dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [9:0]  quotient
);

  logic [15:0] rem;
  logic [9:0]  dvd;
  logic [3:0]  cnt;
  logic        busy;
  logic [16:0] trial;

  assign trial = {rem, dvd[9]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= 16'd0;
        dvd      <= dividend;
        quotient <= 10'd0;
        cnt      <= 4'd0;
      end else if (busy) begin
        // shift in one dividend bit, subtract where it fits
        if (trial >= {1'b0, divisor}) begin
          rem      <= 16'(trial - {1'b0, divisor});
          quotient <= {quotient[8:0], 1'b1};
        end else begin
          rem      <= trial[15:0];
          quotient <= {quotient[8:0], 1'b0};
        end
        dvd <= {dvd[8:0], 1'b0};
        cnt <= cnt + 4'd1;
        if (cnt == 4'd9) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/bitmap_page_allocator.sv =====
// ---------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit page allocator over a 1024 x 64 bit used-page bitmap.
// ---------------------------------------------------------------------------
// After reset a clearing pass sets every one of the 1024 map words to all used;
// no item is taken meanwhile. Free count resets to 0, base page to 8192.
// Free/reserve: each map word touched is read, then written back.
// Allocate: the words of each candidate are scanned in turn; each skip runs
// the serial divider and step multiply, and a fit runs the marking pass.
// One item at a time; no new item is taken until its result is loaded.
module bitmap_page_allocator
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] page,
  input  logic [10:0] count,
  input  logic [15:0] alignment,
  input  logic [16:0] upper_page,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [15:0] start_page,
  output logic [16:0] free_count
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_CLR  = 11'b00000000010,
    S_CHK  = 11'b00000000100,
    S_SRD  = 11'b00000001000,
    S_SCAN = 11'b00000010000,
    S_DIV  = 11'b00000100000,
    S_ADV  = 11'b00001000000,
    S_MRD  = 11'b00010000000,
    S_MWR  = 11'b00100000000,
    S_DONE = 11'b01000000000,
    S_MUL  = 11'b10000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] base_page;
  logic [16:0] total_pages;

  // request context
  logic [10:0] r_count;
  logic [15:0] r_align;
  logic [16:0] r_limit;
  logic [27:0] idx;
  logic [15:0] run_s;
  logic [16:0] run_e;
  logic        mark_used;
  logic [10:0] cur_w;
  logic [9:0]  clr_addr;
  logic [16:0] free_pages;
  logic        res_ok;
  logic [15:0] res_start;
  logic [26:0] step;

  // bitmap memory
  logic [63:0] mem [MAP_WORDS];
  logic [63:0] rdata;
  logic        we;
  logic [9:0]  wa;
  logic [63:0] wd;

  // search helpers
  logic [63:0] cur_mask;
  logic [63:0] hit;
  logic [10:0] last_w;
  logic [15:0] hit_page;
  logic [9:0]  used_off;
  logic        div_start;
  logic        div_done;
  logic [9:0]  div_q;
  logic [16:0] lim_total;
  logic [16:0] lim_req;
  logic [27:0] run_end28;
  logic [17:0] free_sum;
  logic        out_free;

  assign cur_mask  = word_mask(cur_w, run_s, run_e);
  assign hit       = rdata & cur_mask;
  assign last_w    = run_e[16:6] - 11'd1 + {10'd0, (run_e[5:0] != 6'd0)};
  assign hit_page  = {cur_w[9:0], first_set(hit)};
  assign used_off  = 10'(hit_page - run_s);
  assign div_start = (state == S_SCAN) && (hit != 64'd0);
  assign run_end28 = idx + {17'd0, r_count};
  assign free_sum  = {1'b0, free_pages} + {7'd0, count};
  assign out_free  = !out_valid || !out_stall;

  // search limit: total pages clipped to storage, then the request's limit
  assign lim_total = (total_pages > FREE_MAX) ? FREE_MAX : total_pages;
  assign lim_req   = (upper_page != 17'd0 && upper_page < lim_total) ? upper_page
                                                                     : lim_total;

  assign in_stall = (state != S_IDLE);

  // write port: clearing pass or read-modify-write of one map word
  always_comb begin
    we = 1'b0;
    wa = cur_w[9:0];
    wd = mark_used ? (rdata | cur_mask) : (rdata & ~cur_mask);
    if (state == S_CLR) begin
      we = 1'b1;
      wa = clr_addr;
      wd = {64{1'b1}};
    end else if (state == S_MWR) begin
      we = !cur_w[10];
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[cur_w[9:0]];
  end

  bpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (used_off),
    .divisor  (r_align),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_addr    <= 10'd0;
      base_page   <= BASE_RESET;
      total_pages <= TOTAL_RESET;
      free_pages  <= 17'd0;
      out_valid   <= 1'b0;
      cur_w       <= 11'd0;
    end else begin
      if (cfg_write) begin
        unique case (reg_idx_t'(cfg_index))
          REG_BASE:  base_page   <= cfg_data[15:0];
          REG_TOTAL: total_pages <= cfg_data;
        endcase
      end

      // drop the result once taken, unless a new one is loaded this cycle
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;

      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 10'd1;
          if (clr_addr == 10'(MAP_WORDS - 1)) state <= S_IDLE;
        end

        S_IDLE: begin
          if (in_valid) begin
            res_ok    <= 1'b0;
            res_start <= 16'd0;
            r_count   <= count;
            run_s     <= page;
            run_e     <= {1'b0, page} + {6'd0, count};
            cur_w     <= {1'b0, page[15:6]};
            if (count > 11'(MAX_RUN)) begin
              state <= S_DONE;
            end else begin
              unique case (kind_t'(kind))
                KIND_ALLOC: begin
                  r_align <= (alignment == 16'd0) ? 16'd1 : alignment;
                  r_limit <= lim_req;
                  idx     <= {12'd0, base_page};
                  state   <= S_CHK;
                end
                KIND_FREE: begin
                  res_ok     <= 1'b1;
                  mark_used  <= 1'b0;
                  free_pages <= (free_sum > {1'b0, FREE_MAX}) ? FREE_MAX
                                                               : free_sum[16:0];
                  state      <= (count == 11'd0) ? S_DONE : S_MRD;
                end
                KIND_RESERVE: begin
                  res_ok    <= 1'b1;
                  mark_used <= 1'b1;
                  state     <= (count == 11'd0) ? S_DONE : S_MRD;
                end
                KIND_NONE: state <= S_DONE;
              endcase
            end
          end
        end

        // test the candidate against the limit, then scan its words
        S_CHK: begin
          if (idx < {11'd0, r_limit} && run_end28 <= {11'd0, r_limit}) begin
            run_s <= idx[15:0];
            run_e <= run_end28[16:0];
            cur_w <= {1'b0, idx[15:6]};
            if (r_count == 11'd0) begin
              res_ok    <= 1'b1;
              res_start <= idx[15:0];
              state     <= S_DONE;
            end else begin
              state <= S_SRD;
            end
          end else begin
            state <= S_DONE;
          end
        end

        S_SRD: state <= S_SCAN;

        S_SCAN: begin
          if (hit != 64'd0) begin
            state <= S_DIV;
          end else if (cur_w == last_w) begin
            // whole run free: claim it
            res_ok     <= 1'b1;
            res_start  <= run_s;
            mark_used  <= 1'b1;
            free_pages <= (free_pages >= {6'd0, r_count}) ? free_pages - {6'd0, r_count}
                                                         : 17'd0;
            cur_w      <= {1'b0, run_s[15:6]};
            state      <= S_MRD;
          end else begin
            cur_w <= cur_w + 11'd1;
            state <= S_SRD;
          end
        end

        // skip to the first aligned candidate past the used page
        S_DIV: begin
          if (div_done) state <= S_MUL;
        end

        S_MUL: begin
          step  <= 27'(({1'b0, div_q} + 11'd1) * r_align);
          state <= S_ADV;
        end

        S_ADV: begin
          idx   <= idx + {1'b0, step};
          state <= S_CHK;
        end

        S_MRD: state <= S_MWR;

        S_MWR: begin
          if (cur_w == last_w || cur_w[10]) begin
            state <= S_DONE;
          end else begin
            cur_w <= cur_w + 11'd1;
            state <= S_MRD;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            ok         <= res_ok;
            start_page <= res_start;
            free_count <= free_pages;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/page_alloc_checker.sv =====
// ---------------------------------------------------------------------------
// page_alloc_checker
// Watches the configuration, request and result channels of the page
// allocator. It keeps its own copy of the used-page bitmap and free count,
// predicts every result, and compares each result with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module page_alloc_checker
  import bpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] page,
  input  logic [10:0] count,
  input  logic [15:0] alignment,
  input  logic [16:0] upper_page,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        ok,
  input  logic [15:0] start_page,
  input  logic [16:0] free_count,
  output int          pending,
  output int          errors
);

  typedef struct packed {
    logic        ok;
    logic [15:0] start;
    logic [16:0] free;
  } page_result_t;

  bit           used_pages [NUM_PAGES];
  int unsigned  free_pages_m;
  int unsigned  base_m;
  int unsigned  total_m;
  page_result_t expected_q [$];

  initial begin
    pending = 0;
    errors  = 0;
  end

  function automatic bit page_taken(int unsigned p);
    if (p >= NUM_PAGES) return 1'b1;
    return used_pages[p];
  endfunction

  function automatic void mark_pages(int unsigned p, int unsigned n, bit v);
    for (int unsigned i = 0; i < n; i++) begin
      if (p + i >= NUM_PAGES) break;
      used_pages[p + i] = v;
    end
  endfunction

  function automatic page_result_t allocate_pages(kind_t k, int unsigned pg,
                                                  int unsigned cnt, int unsigned al,
                                                  int unsigned up);
    page_result_t r;
    int unsigned  lim;
    int unsigned  idx;
    int unsigned  i;
    bit           fits;
    r = '0;
    if (cnt <= MAX_RUN) begin
      case (k)
        KIND_ALLOC: begin
          lim = (total_m > NUM_PAGES) ? NUM_PAGES : total_m;
          if (up != 0 && up < lim) lim = up;
          if (al == 0) al = 1;
          idx = base_m;
          while (idx < lim && idx + cnt <= lim) begin
            fits = 1'b1;
            for (i = 0; i < cnt; i++) begin
              if (page_taken(idx + i)) begin
                fits = 1'b0;
                break;
              end
            end
            if (fits) begin
              mark_pages(idx, cnt, 1'b1);
              free_pages_m = (free_pages_m >= cnt) ? free_pages_m - cnt : 0;
              r.ok    = 1'b1;
              r.start = idx[15:0];
              break;
            end
            // jump to the first aligned candidate beyond the used page
            idx += (i / al + 1) * al;
          end
        end
        KIND_FREE: begin
          mark_pages(pg, cnt, 1'b0);
          free_pages_m += cnt;
          if (free_pages_m > FREE_MAX) free_pages_m = FREE_MAX;
          r.ok = 1'b1;
        end
        KIND_RESERVE: begin
          mark_pages(pg, cnt, 1'b1);
          r.ok = 1'b1;
        end
        default: ;
      endcase
    end
    r.free = free_pages_m[16:0];
    return r;
  endfunction

  always @(posedge clk) begin
    page_result_t want;
    if (rst) begin
      for (int p = 0; p < NUM_PAGES; p++) used_pages[p] = 1'b1;
      free_pages_m = 0;
      base_m       = BASE_RESET;
      total_m      = TOTAL_RESET;
      expected_q.delete();
    end else begin
      if (cfg_write) begin
        case (reg_idx_t'(cfg_index))
          REG_BASE:  base_m  = cfg_data[15:0];
          REG_TOTAL: total_m = cfg_data;
        endcase
      end
      if (in_valid && !in_stall)
        expected_q.push_back(allocate_pages(kind_t'(kind), page, count,
                                            alignment, upper_page));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result ok=%0d start=%0d free=%0d",
                     $time, ok, start_page, free_count);
        end else begin
          want = expected_q.pop_front();
          if (ok !== want.ok || start_page !== want.start || free_count !== want.free) begin
            errors++;
            if (errors <= 10)
              $display("%0t: result mismatch ok %0d/%0d start %0d/%0d free %0d/%0d",
                       $time, want.ok, ok, want.start, start_page,
                       want.free, free_count);
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Regression for the bitmap page allocator: a directed opening, then
// phases of random allocate, free and reserve items under several base and
// total page settings, with random idling on both channels and one long
// result hold-off. The checker predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bpa_pkg::*;

  localparam int LIMIT_CYCLES = 50_000_000;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [16:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [15:0] page;
  logic [10:0] count;
  logic [15:0] alignment;
  logic [16:0] upper_page;
  logic        out_valid;
  logic        out_stall;
  logic        ok;
  logic [15:0] start_page;
  logic [16:0] free_count;

  int pending;
  int errors;
  int cycles;
  int cur_base;
  int cur_total;
  bit quiet;       // no idling on either side while set
  bit long_hold;   // ask the receiver for one long stall

  bitmap_page_allocator DUT (.*);

  page_alloc_checker checker_i (.*);

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("bitmap_page_allocator regression: fail");
      $finish;
    end
  end

  // Receiver: draw a stall for each result; on request hold off for a long
  // stretch so the block backs up and stalls its input.
  initial begin
    int n;
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end
      n = quiet ? 0 : $urandom_range(0, 4);
      out_stall = (n != 0);
      repeat (n) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Write one register at the falling edge; registers are to change only when idle, which the block does not enforce.
  task automatic write_reg(reg_idx_t idx, logic [16:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Drain outstanding results, let the block settle, then reprogram.
  task automatic set_window(int base, int total);
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    write_reg(REG_BASE, base[16:0]);
    write_reg(REG_TOTAL, total[16:0]);
    cur_base  = base;
    cur_total = total;
  endtask

  // Offer one item after a random gap; hold it until accepted, then drop valid.
  task automatic send_request(kind_t k, int pg, int cnt, int al, int up);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   = 1'b1;
    kind       = k;
    page       = pg[15:0];
    count      = cnt[10:0];
    alignment  = al[15:0];
    upper_page = up[16:0];
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Random item: allocates search a bounded window above the base so a scan
  // stays short; runs to free or reserve mostly land near the base.
  task automatic send_random_request();
    int r, k, pg, cnt, al, up;
    r = $urandom_range(0, 99);
    if (r < 45)      k = KIND_ALLOC;
    else if (r < 75) k = KIND_FREE;
    else if (r < 96) k = KIND_RESERVE;
    else             k = KIND_NONE;
    r = $urandom_range(0, 99);
    if (r < 70)      cnt = $urandom_range(0, 64);
    else if (r < 95) cnt = $urandom_range(65, MAX_RUN);
    else             cnt = $urandom_range(MAX_RUN + 1, 2047);
    r = $urandom_range(0, 99);
    if (r < 70)      al = $urandom_range(0, 8);
    else if (r < 85) al = 1 << $urandom_range(4, 10);
    else             al = $urandom_range(0, 65535);
    if ($urandom_range(0, 9) < 7)
      pg = (cur_base + $urandom_range(0, 1200)) & 16'hffff;
    else
      pg = $urandom_range(0, 65535);
    r = $urandom_range(0, 99);
    if (r < 75) begin
      up = cur_base + $urandom_range(1, 1024);
      if (up > 65536) up = 65536;
    end else if (r < 90 || cur_total > cur_base + 1024) begin
      up = $urandom_range(1, cur_base + 1);   // at most one past the base: quick result
    end else begin
      up = 0;                                  // no limit, only for short ranges
    end
    send_request(kind_t'(k), pg, cnt, al, up);
  endtask

  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = REG_BASE;
    cfg_data   = '0;
    in_valid   = 1'b0;
    kind       = KIND_ALLOC;
    page       = '0;
    count      = '0;
    alignment  = '0;
    upper_page = '0;
    quiet      = 1'b0;
    long_hold  = 1'b0;
    cur_base   = BASE_RESET;
    cur_total  = TOTAL_RESET;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed opening at reset settings; the map starts all used
    send_request(KIND_ALLOC, 0, 1, 1, 8192 + 64);         // nothing free
    send_request(KIND_FREE, 8192, MAX_RUN, 0, 0);
    send_request(KIND_FREE, 8192, 0, 0, 0);               // zero length
    send_request(KIND_FREE, 8192, MAX_RUN + 1, 0, 0);     // oversized, dropped
    send_request(KIND_RESERVE, 8192, 2047, 0, 0);         // oversized, dropped
    send_request(KIND_ALLOC, 0, 2047, 1, 0);              // oversized, dropped
    send_request(KIND_ALLOC, 0, 0, 0, 0);                 // zero length at base
    send_request(KIND_ALLOC, 0, MAX_RUN, 0, 0);           // whole run, no limit
    send_request(KIND_FREE, 8192, 64, 0, 0);
    send_request(KIND_ALLOC, 0, 16, 65535, 65536);        // widest step
    send_request(KIND_ALLOC, 0, 8, 16, 8192 + 64);
    send_request(KIND_ALLOC, 0, 40, 1, 8192 + 64);        // fills the room left exactly
    send_request(KIND_ALLOC, 0, 1, 1, 100);               // limit below base
    send_request(KIND_RESERVE, 65535, MAX_RUN, 0, 0);     // runs off the top
    send_request(KIND_FREE, 65535, MAX_RUN, 0, 0);
    send_request(KIND_FREE, 8192 + 64, 32, 0, 0);
    send_request(KIND_RESERVE, 8192 + 64, 8, 0, 0);
    send_request(KIND_ALLOC, 0, 8, 1, 8192 + 128);        // skips the reserved run
    send_request(KIND_NONE, 65535, 2047, 65535, 131071);  // unknown kind
    send_request(KIND_ALLOC, 65535, 4, 3, 8192 + 200);

    // random phases, extremes of both registers among them
    set_window(0, 4096);
    repeat (180) send_random_request();
    set_window(64512, 65536);
    repeat (180) send_random_request();
    set_window(30000, 0);                                 // nothing can be allocated
    repeat (60) send_random_request();
    set_window(BASE_RESET, TOTAL_RESET);
    quiet = 1'b1;                                         // a stretch with no idling
    repeat (60) send_random_request();
    quiet = 1'b0;
    long_hold = 1'b1;
    repeat (120) send_random_request();
    set_window(65535, 65536);
    repeat (60) send_random_request();
    set_window(40000, 40800);
    repeat (160) send_random_request();

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0)
      $display("bitmap_page_allocator regression: pass");
    else
      $display("bitmap_page_allocator regression: fail");
    $finish;
  end

endmodule

// ===== bitmap_page_allocator.f =====
rtl/core/bpa_pkg.sv
rtl/core/bpa_div.sv
rtl/core/bitmap_page_allocator.sv
sim/page_alloc_checker.sv
sim/testbench.sv
